// ===== hw/rtl/psh_pkg.sv =====
// ----------------------------------------------------------------------------
// psh_pkg: shared types and constants of the priority-sorted handler chain
// Request and response codes, sequencer states and the stored entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package psh_pkg;

	localparam int CHAIN_DEPTH = 16;
	localparam int ELEM_W      = 32;
	localparam int PRIO_W      = 32;
	localparam int COUNT_W     = 5;
	localparam int STATUS_W    = 3;

	// request kinds
	localparam logic KIND_ENQ = 1'b0;
	localparam logic KIND_DEQ = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_REGISTERED = 3'd0,
		ST_REMOVED    = 3'd1,
		ST_NOT_FOUND  = 3'd2,
		ST_DROPPED    = 3'd3,
		ST_IGNORED    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_REMOVE,
		S_INSERT,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [ELEM_W-1:0] elem;
	} entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/psh_req_if.sv =====
// ----------------------------------------------------------------------------
// psh_req_if: request channel of the handler chain
// Valid/ready handshake carrying the kind, priority and element address.
// ----------------------------------------------------------------------------
`default_nettype none

interface psh_req_if;
	logic                        valid;
	logic                        ready;
	logic                        kind;
	logic [psh_pkg::PRIO_W-1:0]  priority_req;
	logic [psh_pkg::ELEM_W-1:0]  element;

	modport source (output valid, output kind, output priority_req, output element,
		input ready);
	modport sink (input valid, input kind, input priority_req, input element,
		output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/psh_rsp_if.sv =====
// ----------------------------------------------------------------------------
// psh_rsp_if: response channel of the handler chain
// Valid/ready handshake carrying the status code and the entry count.
// ----------------------------------------------------------------------------
`default_nettype none

interface psh_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [psh_pkg::STATUS_W-1:0]  status;
	logic [psh_pkg::COUNT_W-1:0]   count;

	modport source (output valid, output status, output count, input ready);
	modport sink (input valid, input status, input count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/psh_ram.sv =====
// ----------------------------------------------------------------------------
// psh_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module psh_ram #(
	parameter int WIDTH = $bits(psh_pkg::entry_t),
	parameter int DEPTH = psh_pkg::CHAIN_DEPTH
) (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [$clog2(DEPTH)-1:0]  waddr,
	input  wire logic [WIDTH-1:0]          wdata,
	input  wire logic [$clog2(DEPTH)-1:0]  raddr,
	output logic      [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/priority_sorted_handler_chain.sv =====
// ----------------------------------------------------------------------------
// priority_sorted_handler_chain: bounded priority-sorted list of handlers
// Sorted insertion and removal of element addresses held in one RAM.
// ----------------------------------------------------------------------------
// usage
//   req channel: one request carries kind (enqueue or dequeue), priority and
//   element address; it is taken when req.valid and req.ready are both high
//   rsp channel: exactly one response per request with a status code and the
//   number of entries afterwards, in request order
//   the list lives in a RAM with a registered read; a request first walks the
//   list to drop an existing copy, then an enqueue with room walks down from
//   the tail shifting entries up to its slot on the list left after the drop,
//   and S_FINISH loads the response; the walks use the single RAM read port;
//   a full list holds 16 entries; a dequeue answers after the removal walk,
//   and an ignored zero enqueue skips both walks and goes straight to S_FINISH
//   one request is worked at a time; req.ready is high only while idle
//   a finished response sits in the output register; a new request may be
//   taken while it waits, but its own response holds until rsp.ready frees
//   the register
//   reset empties the list by clearing the count; RAM contents stay as they
//   are and are never read before being written, so no clearing pass runs
// ----------------------------------------------------------------------------
`default_nettype none

module priority_sorted_handler_chain #(
	parameter int CHAIN_DEPTH = psh_pkg::CHAIN_DEPTH
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	psh_req_if.sink     req,
	psh_rsp_if.source   rsp
);

	localparam int AW = $clog2(CHAIN_DEPTH);
	localparam int CW = $clog2(CHAIN_DEPTH + 1);
	localparam int EW = $bits(psh_pkg::entry_t);

	// sequencer state
	psh_pkg::state_t   state_q, state_d;
	logic [CW-1:0]     cnt_q, cnt_d;
	logic [CW-1:0]     idx_q, idx_d;      // next read position of the walk
	logic [AW-1:0]     at_q, at_d;        // free slot while shifting up
	logic              found_q, found_d;  // old copy already passed
	psh_pkg::status_t  status_q, status_d;

	// read in flight, data shows next cycle
	logic              pend_s1, pend_d;
	logic [AW-1:0]     tag_s1, tag_d;

	// request payload
	logic                        kind_q;
	logic [psh_pkg::PRIO_W-1:0]  prio_q;
	logic [psh_pkg::ELEM_W-1:0]  elem_q;

	// response register
	logic                          out_valid_q;
	logic [psh_pkg::STATUS_W-1:0]  out_status_q;
	logic [psh_pkg::COUNT_W-1:0]   out_count_q;
	logic                          load_out;

	// ram port
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	psh_pkg::entry_t    ram_wdata;
	logic [AW-1:0]      ram_raddr;
	psh_pkg::entry_t    ram_rdata;
	logic [EW-1:0]      ram_rdata_raw;

	logic               accept;
	logic [CW-1:0]      cnt_rm;
	logic [CW-1:0]      idx_m1;
	logic [CW+4:0]      cnt_ext;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == psh_pkg::S_IDLE);
	assign ram_rdata = psh_pkg::entry_t'(ram_rdata_raw);

	// count after the removal walk
	assign cnt_rm  = found_q ? (cnt_q - CW'(1)) : cnt_q;
	assign idx_m1  = idx_q - CW'(1);
	// the reported count is the low five bits
	assign cnt_ext = {5'b0, cnt_q};

	psh_ram #(
		.WIDTH (EW),
		.DEPTH (CHAIN_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata_raw)
	);

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		at_d      = at_q;
		found_d   = found_q;
		status_d  = status_q;
		pend_d    = 1'b0;
		tag_d     = tag_s1;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = ram_rdata;
		ram_raddr = '0;
		load_out  = 1'b0;

		unique case (state_q)
			psh_pkg::S_IDLE: begin
				if (req.valid) begin
					idx_d   = '0;
					found_d = 1'b0;
					if (req.kind == psh_pkg::KIND_ENQ && req.element == '0) begin
						status_d = psh_pkg::ST_IGNORED;
						state_d  = psh_pkg::S_FINISH;
					end else begin
						state_d = psh_pkg::S_REMOVE;
					end
				end
			end

			psh_pkg::S_REMOVE: begin
				// stream reads upward through the live entries
				if (idx_q < cnt_q) begin
					ram_raddr = idx_q[AW-1:0];
					pend_d    = 1'b1;
					tag_d     = idx_q[AW-1:0];
					idx_d     = idx_q + CW'(1);
				end
				if (pend_s1) begin
					if (found_q) begin
						// close the gap: entry moves down one slot
						ram_we    = 1'b1;
						ram_waddr = tag_s1 - AW'(1);
						ram_wdata = ram_rdata;
					end else if (ram_rdata.elem == elem_q) begin
						found_d = 1'b1;
					end
				end else if (idx_q == cnt_q) begin
					cnt_d = cnt_rm;
					if (kind_q == psh_pkg::KIND_DEQ) begin
						status_d = found_q ? psh_pkg::ST_REMOVED : psh_pkg::ST_NOT_FOUND;
						state_d  = psh_pkg::S_FINISH;
					end else if (cnt_rm >= CW'(CHAIN_DEPTH)) begin
						status_d = psh_pkg::ST_DROPPED;
						state_d  = psh_pkg::S_FINISH;
					end else begin
						idx_d   = cnt_rm;
						at_d    = cnt_rm[AW-1:0];
						state_d = psh_pkg::S_INSERT;
					end
				end
			end

			psh_pkg::S_INSERT: begin
				// read downward from the tail, one entry ahead
				if (idx_q != '0) begin
					ram_raddr = idx_m1[AW-1:0];
					pend_d    = 1'b1;
					tag_d     = idx_m1[AW-1:0];
					idx_d     = idx_m1;
				end
				if (pend_s1 && ram_rdata.prio > prio_q) begin
					// larger priority value moves up one slot
					ram_we    = 1'b1;
					ram_waddr = tag_s1 + AW'(1);
					ram_wdata = ram_rdata;
					at_d      = tag_s1;
				end else if (pend_s1 || idx_q == '0) begin
					ram_we         = 1'b1;
					ram_waddr      = at_q;
					ram_wdata.prio = prio_q;
					ram_wdata.elem = elem_q;
					cnt_d          = cnt_q + CW'(1);
					status_d       = psh_pkg::ST_REGISTERED;
					pend_d         = 1'b0;
					state_d        = psh_pkg::S_FINISH;
				end
			end

			psh_pkg::S_FINISH: begin
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = psh_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = psh_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= psh_pkg::S_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			at_q        <= '0;
			found_q     <= 1'b0;
			status_q    <= psh_pkg::ST_REGISTERED;
			pend_s1     <= 1'b0;
			tag_s1      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			idx_q    <= idx_d;
			at_q     <= at_d;
			found_q  <= found_d;
			status_q <= status_d;
			pend_s1  <= pend_d;
			tag_s1   <= tag_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= req.kind;
			prio_q <= req.priority_req;
			elem_q <= req.element;
		end
		if (load_out) begin
			out_status_q <= status_q;
			out_count_q  <= cnt_ext[psh_pkg::COUNT_W-1:0];
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.count  = out_count_q;

endmodule

`default_nettype wire

// ===== hw/rtl/psh_chk.sv =====
// ----------------------------------------------------------------------------
// psh_chk: port-level checks of the handler chain
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module psh_chk #(
	parameter int CHAIN_DEPTH = psh_pkg::CHAIN_DEPTH
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          req_valid,
	input wire logic                          req_ready,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_ready,
	input wire logic [psh_pkg::STATUS_W-1:0]  rsp_status,
	input wire logic [psh_pkg::COUNT_W-1:0]   rsp_count
);

	localparam logic [psh_pkg::COUNT_W-1:0] FULL_CNT = psh_pkg::COUNT_W'(CHAIN_DEPTH);

	// one request in work at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while another is in work");

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=>
		(rsp_valid && $stable(rsp_status) && $stable(rsp_count)))
		else $error("stalled response changed");

	// a dropped enqueue is only reported with a full list
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_status == psh_pkg::ST_DROPPED) |-> (rsp_count == FULL_CNT))
		else $error("drop reported without a full list");

	// a registration leaves at least one entry
	a_reg_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_status == psh_pkg::ST_REGISTERED && CHAIN_DEPTH < 32)
		|-> (rsp_count != '0))
		else $error("registration reported an empty list");

endmodule

bind priority_sorted_handler_chain psh_chk #(
	.CHAIN_DEPTH (CHAIN_DEPTH)
) u_psh_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_count  (rsp.count)
);

`default_nettype wire

// ===== sim/tb_priority_sorted_handler_chain.sv =====
// ----------------------------------------------------------------------------
// tb_priority_sorted_handler_chain: self-checking bench for the handler chain
// Drives enqueue and dequeue requests with random gaps and response stalls,
// predicts status and count from a behavioral copy of the sorted list, and
// compares every response in order.
// ----------------------------------------------------------------------------
module tb_priority_sorted_handler_chain;
	timeunit 1ns;
	timeprecision 1ps;

	import psh_pkg::*;

	// a quiet stretch this long with no handshake on either side is a hang
	localparam int HANG_LIMIT  = 2000;
	// settle time after the last response
	localparam int TAIL_CYCLES = 40;
	localparam int RAND_REQS   = 400;
	localparam int POOL_SIZE   = 24;

	typedef struct {
		logic              kind;
		logic [PRIO_W-1:0] prio;
		logic [ELEM_W-1:0] elem;
		bit                drain;  // not a request: sender waits for all responses
	} chain_req_t;

	typedef struct {
		status_t            status;
		logic [COUNT_W-1:0] count;
	} chain_reply_t;

	logic clk;
	logic arst_n;

	psh_req_if req_ch ();
	psh_rsp_if rsp_ch ();

	priority_sorted_handler_chain u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// requests waiting to be driven and responses still owed by the block
	chain_req_t   req_backlog[$];
	chain_reply_t owed_replies[$];

	// behavioral copy of the sorted list
	logic [ELEM_W-1:0] chain_elem[CHAIN_DEPTH];
	logic [PRIO_W-1:0] chain_prio[CHAIN_DEPTH];
	int                chain_len;

	int  req_sent;
	int  req_taken;
	int  mismatches;
	int  quiet_cycles;
	bit  calm;

	logic [ELEM_W-1:0] elem_pool[POOL_SIZE];

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// no random stalls on either side while this window of requests goes through
	assign calm = (req_taken >= 150) && (req_taken < 260);

	// ------------------------------------------------------------------------
	// list predictor
	// ------------------------------------------------------------------------

	// take out the first copy of elem, closing the gap; reports whether found
	function automatic bit chain_unlink(input logic [ELEM_W-1:0] elem);
		for (int i = 0; i < chain_len; i++) begin
			if (chain_elem[i] == elem) begin
				for (int j = i; j + 1 < chain_len; j++) begin
					chain_elem[j] = chain_elem[j + 1];
					chain_prio[j] = chain_prio[j + 1];
				end
				chain_len--;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic chain_reply_t chain_apply(input chain_req_t r);
		chain_reply_t res;
		int           slot;
		if (r.kind == KIND_DEQ) begin
			// zero is never stored, so a zero dequeue simply misses
			res.status = chain_unlink(r.elem) ? ST_REMOVED : ST_NOT_FOUND;
		end else if (r.elem == '0) begin
			res.status = ST_IGNORED;
		end else begin
			// a re-registration drops the old copy before placing the new one
			void'(chain_unlink(r.elem));
			if (chain_len >= CHAIN_DEPTH) begin
				res.status = ST_DROPPED;
			end else begin
				// walk down from the tail; equal priority stays behind older entries
				slot = chain_len;
				while (slot > 0 && chain_prio[slot - 1] > r.prio) begin
					chain_elem[slot] = chain_elem[slot - 1];
					chain_prio[slot] = chain_prio[slot - 1];
					slot--;
				end
				chain_elem[slot] = r.elem;
				chain_prio[slot] = r.prio;
				chain_len++;
				res.status = ST_REGISTERED;
			end
		end
		res.count = COUNT_W'(chain_len);
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// request driver: changes on the falling edge
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		bit stall;
		chain_req_t r;
		stall = !calm && ($urandom_range(99) < 12);
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (req_ch.valid && req_sent != req_taken) begin
			// request still on the bus, hold it
		end else if (stall || req_backlog.size() == 0) begin
			req_ch.valid        <= 1'b0;
			req_ch.kind         <= 1'($urandom);
			req_ch.priority_req <= $urandom;
			req_ch.element      <= $urandom;
		end else if (req_backlog[0].drain) begin
			// pause the sender until every response is in
			if (owed_replies.size() == 0) begin
				void'(req_backlog.pop_front());
			end
			req_ch.valid <= 1'b0;
		end else begin
			r = req_backlog.pop_front();
			req_ch.valid        <= 1'b1;
			req_ch.kind         <= r.kind;
			req_ch.priority_req <= r.prio;
			req_ch.element      <= r.elem;
			req_sent++;
		end
	end

	// response sink: random backpressure outside the calm window
	always @(negedge clk) begin
		rsp_ch.ready <= (!calm && $urandom_range(99) < 12) ? 1'b0 : 1'b1;
	end

	// ------------------------------------------------------------------------
	// monitor: samples on the rising edge, predicts and checks
	// ------------------------------------------------------------------------
	function automatic void flag_mismatch(input string what, input chain_reply_t want,
		input logic [STATUS_W-1:0] got_status, input logic [COUNT_W-1:0] got_count);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: %s: expected status %0d (%s) count %0d, got status %0d count %0d",
				$realtime, what, want.status, want.status.name(), want.count,
				got_status, got_count);
		end
	endfunction

	always @(posedge clk) begin
		chain_req_t   r;
		chain_reply_t want;
		bit           moved;
		moved = 1'b0;
		if (arst_n) begin
			// expectation goes in before the response check: the queue is in order
			if (req_ch.valid && req_ch.ready) begin
				r.kind  = req_ch.kind;
				r.prio  = req_ch.priority_req;
				r.elem  = req_ch.element;
				r.drain = 1'b0;
				owed_replies.push_back(chain_apply(r));
				req_taken++;
				moved = 1'b1;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				moved = 1'b1;
				if (owed_replies.size() == 0) begin
					want.status = ST_IGNORED;
					want.count  = '0;
					flag_mismatch("response with no request outstanding", want,
						rsp_ch.status, rsp_ch.count);
				end else begin
					want = owed_replies.pop_front();
					if (rsp_ch.status !== want.status || rsp_ch.count !== want.count) begin
						flag_mismatch("response mismatch", want, rsp_ch.status, rsp_ch.count);
					end
				end
			end
		end
		// hang watchdog: counts edges with no handshake at all
		if (moved) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("%0t: no handshake for %0d cycles, %0d responses owed",
					$realtime, HANG_LIMIT, owed_replies.size());
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	function automatic void queue_req(input logic kind, input logic [PRIO_W-1:0] prio,
		input logic [ELEM_W-1:0] elem);
		chain_req_t r;
		r.kind  = kind;
		r.prio  = prio;
		r.elem  = elem;
		r.drain = 1'b0;
		req_backlog.push_back(r);
	endfunction

	function automatic void queue_drain();
		chain_req_t r;
		r.kind  = KIND_ENQ;
		r.prio  = '0;
		r.elem  = '0;
		r.drain = 1'b1;
		req_backlog.push_back(r);
	endfunction

	initial begin
		int               enq_pct;
		int               pick;
		logic [ELEM_W-1:0] e;
		logic [PRIO_W-1:0] p;

		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.kind         = KIND_ENQ;
		req_ch.priority_req = '0;
		req_ch.element      = '0;
		rsp_ch.ready        = 1'b1;
		chain_len           = 0;
		req_sent            = 0;
		req_taken           = 0;
		mismatches          = 0;
		quiet_cycles        = 0;

		// directed part
		queue_req(KIND_DEQ, 32'h0, 32'h0000_0005);          // dequeue on empty list
		queue_req(KIND_DEQ, 32'h0, 32'h0);                  // zero dequeue misses
		queue_req(KIND_ENQ, 32'hFFFF_FFFF, 32'h0);          // zero enqueue is ignored
		queue_req(KIND_ENQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // top of both ranges
		queue_req(KIND_ENQ, 32'h0, 32'h0000_0001);          // lowest priority value
		queue_req(KIND_ENQ, 32'd7, 32'h0000_000A);
		queue_req(KIND_ENQ, 32'd7, 32'h0000_000B);          // tie lands behind older
		queue_req(KIND_ENQ, 32'd3, 32'h0000_000A);          // re-register moves it
		// fill the list to its depth
		for (int i = 0; i < CHAIN_DEPTH - 4; i++) begin
			queue_req(KIND_ENQ, PRIO_W'(i * 3), ELEM_W'(32'h100 + i));
		end
		queue_req(KIND_ENQ, 32'd1, 32'h0000_0200);          // full list drops it
		queue_req(KIND_ENQ, 32'd1, 32'h0000_000B);          // present element fits when full
		queue_req(KIND_DEQ, 32'h0, 32'h0000_000A);
		queue_req(KIND_DEQ, 32'h0, 32'h0000_000A);          // second removal misses
		queue_req(KIND_DEQ, 32'h0, 32'h0);
		queue_drain();

		// small address pool so that hits, re-registrations and full lists happen
		foreach (elem_pool[i]) begin
			elem_pool[i] = $urandom;
			if (elem_pool[i] == '0) begin
				elem_pool[i] = 32'h1;
			end
		end

		// random part: alternate fill-leaning and drain-leaning stretches
		enq_pct = 75;
		for (int n = 0; n < RAND_REQS; n++) begin
			if (n % 60 == 59) begin
				enq_pct = (enq_pct > 50) ? 30 : 75;
			end
			if (n % 100 == 99) begin
				queue_drain();
			end
			pick = $urandom_range(99);
			if (pick < 3) begin
				e = '0;
			end else if (pick < 13) begin
				e = $urandom;
			end else begin
				e = elem_pool[$urandom_range(POOL_SIZE - 1)];
			end
			pick = $urandom_range(99);
			if (pick < 50) begin
				p = PRIO_W'($urandom_range(7));
			end else if (pick < 55) begin
				p = '0;
			end else if (pick < 60) begin
				p = '1;
			end else begin
				p = $urandom;
			end
			queue_req(($urandom_range(99) < enq_pct) ? KIND_ENQ : KIND_DEQ, p, e);
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// wait for everything to drain, then let the block settle
		while (req_backlog.size() != 0 || req_ch.valid || owed_replies.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && owed_replies.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches, %0d responses never arrived",
				mismatches, owed_replies.size());
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
